/* rtl/core/lgge_pkg.sv */
// ----------------------------------------------------------------------------
// lgge_pkg
// Shared types, widths and constants of the life grid generation engine.
// ----------------------------------------------------------------------------
package lgge_pkg;

  // field widths of the transfer payloads and the side register
  localparam int OP_W    = 2;
  localparam int COORD_W = 6;
  localparam int SIDE_W  = 7;

  // default largest grid side
  localparam int LGGE_MAX_SIDE = 64;

  // neighbor counts of the life rule
  localparam int SURVIVE_LO_COUNT = 2;
  localparam int BIRTH_COUNT      = 3;

  // operation codes of an input transfer
  typedef enum logic [OP_W-1:0] {
    OP_READ   = 2'd0,
    OP_TOGGLE = 2'd1,
    OP_FILL   = 2'd2,
    OP_STEP   = 2'd3
  } lgge_op_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_STEP,
    ST_READ_ROW,
    ST_RESP
  } lgge_state_t;

endpackage : lgge_pkg

/* rtl/core/lgge_if.sv */
// ----------------------------------------------------------------------------
// lgge_if
// Valid/ready channels for command transfers in and result transfers out.
// ----------------------------------------------------------------------------
interface lgge_in_if
  import lgge_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    operation;
  logic [COORD_W-1:0] cell_x;
  logic [COORD_W-1:0] cell_y;
  logic               fill_value;

  modport source (output valid, output operation, output cell_x, output cell_y,
                  output fill_value, input ready);
  modport sink   (input valid, input operation, input cell_x, input cell_y,
                  input fill_value, output ready);
endinterface : lgge_in_if

interface lgge_out_if;
  logic valid;
  logic ready;
  logic cell_value;
  logic status;

  modport source (output valid, output cell_value, output status, input ready);
  modport sink   (input valid, input cell_value, input status, output ready);
endinterface : lgge_out_if

/* rtl/core/life_grid_generation_engine.sv */
// ----------------------------------------------------------------------------
// life_grid_generation_engine
// Bounded Conway life grid held in a row memory, one row updated per cycle.
// ----------------------------------------------------------------------------
// Usage:
//   in_chan carries one command per transfer: read a cell, toggle a cell,
//   fill the active grid with fill_value, or advance one generation.
//   out_chan returns one result per command: the addressed cell after the
//   operation and a status (1 when the coordinate lies outside the grid,
//   in which case nothing changes and the cell reads 0).
//   cfg_we/cfg_wdata write the grid side; write it only while idle.
// Command sequencing:
//   read, toggle               : ST_READ_ROW, then ST_RESP
//   outside grid               : straight to ST_RESP
//   fill                       : one row read-modify-write per cycle
//                                through the single row memory, then ST_READ_ROW, ST_RESP
//   step                       : one row of new cells per cycle, set by
//                                the one read port sweeping rows, then ST_READ_ROW, ST_RESP
//   One command is in work at a time; in_chan.ready is high only when idle.
// Reset: all cells read as dead at once (per-row valid flags), the side
//   returns to MAX_SIDE. When out_chan stalls, the finished result waits in
//   the output register; the block may still take and work one more command,
//   then waits in ST_RESP until the register frees.
// ----------------------------------------------------------------------------
module life_grid_generation_engine
  import lgge_pkg::*;
#(
  parameter int MAX_SIDE = LGGE_MAX_SIDE
) (
  input  logic              clk,
  input  logic              rst_n,
  lgge_in_if.sink           in_chan,
  lgge_out_if.source        out_chan,
  input  logic              cfg_we,
  input  logic [SIDE_W-1:0] cfg_wdata
);

  localparam int AW = $clog2(MAX_SIDE);
  localparam int CW = $clog2(MAX_SIDE + 2);

  typedef logic [MAX_SIDE-1:0] row_t;

  // row memory and its per-row valid flags
  row_t              mem [MAX_SIDE];
  row_t              mem_q;
  logic              rd_valid_r;
  logic [MAX_SIDE-1:0] row_valid_r;

  logic              mem_re;
  logic [AW-1:0]     mem_ra;
  logic              mem_we;
  logic [AW-1:0]     mem_wa;
  row_t              mem_wd;

  // control and data registers
  lgge_state_t       state_r, state_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  row_t              prev_r, prev_nxt;
  row_t              cur_r, cur_nxt;
  lgge_op_t          op_r;
  logic [COORD_W-1:0] x_r, y_r;
  logic              fill_r;
  logic              oob_r;
  logic [SIDE_W-1:0] grid_side_r;
  logic              out_valid_r;
  logic              out_value_r;
  logic              out_status_r;

  logic [SIDE_W-1:0] eff_side;
  row_t              side_mask;
  row_t              rdata;
  row_t              next_in;
  row_t              new_row;
  row_t              y_bit;
  logic              in_oob;
  logic              in_xfer;
  logic              slot_free;
  logic              out_load;
  logic              res_value;
  logic              res_status;
  logic [CW-1:0]     cnt_m1;
  logic [CW-1:0]     cnt_m2;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_side_r <= SIDE_W'(MAX_SIDE);
    end else if (cfg_we) begin
      grid_side_r <= cfg_wdata;
    end
  end

  // effective side and active column mask
  assign eff_side = (grid_side_r > SIDE_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : grid_side_r;

  always_comb begin
    for (int c = 0; c < MAX_SIDE; c++) begin
      side_mask[c] = (SIDE_W'(c) < eff_side);
    end
  end

  // row memory, one read and one write port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      mem_q <= mem[mem_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_valid_r <= '0;
      rd_valid_r  <= 1'b0;
    end else begin
      if (mem_we) begin
        row_valid_r[mem_wa] <= 1'b1;
      end
      if (mem_re) begin
        rd_valid_r <= row_valid_r[mem_ra];
      end
    end
  end

  // a row never written reads as dead
  assign rdata = rd_valid_r ? mem_q : '0;

  // input decode
  assign in_xfer = in_chan.valid && in_chan.ready;
  assign in_oob  = (SIDE_W'(in_chan.cell_x) >= eff_side) ||
                   (SIDE_W'(in_chan.cell_y) >= eff_side);
  assign in_chan.ready = (state_r == ST_IDLE);

  assign cnt_m1 = cnt_r - CW'(1);
  assign cnt_m2 = cnt_r - CW'(2);
  assign y_bit  = row_t'(1) << y_r[AW-1:0];

  // incoming old row of the step window, dead past the last active row
  assign next_in = ((cnt_r != '0) && (SIDE_W'(cnt_r) <= eff_side)) ? rdata : '0;

  // life rule over one row, columns outside the grid count as dead
  always_comb begin
    logic [MAX_SIDE+1:0] pp, cc, nn;
    logic [3:0]          n_cnt;
    pp = {1'b0, prev_r & side_mask, 1'b0};
    cc = {1'b0, cur_r & side_mask, 1'b0};
    nn = {1'b0, next_in & side_mask, 1'b0};
    new_row = cur_r & ~side_mask;
    for (int c = 0; c < MAX_SIDE; c++) begin
      n_cnt = 4'(pp[c]) + 4'(pp[c+1]) + 4'(pp[c+2]) +
              4'(cc[c]) + 4'(cc[c+2]) +
              4'(nn[c]) + 4'(nn[c+1]) + 4'(nn[c+2]);
      if (cc[c+1]) begin
        new_row[c] = side_mask[c] &&
                     ((n_cnt == 4'(SURVIVE_LO_COUNT)) || (n_cnt == 4'(BIRTH_COUNT)));
      end else begin
        new_row[c] = side_mask[c] && (n_cnt == 4'(BIRTH_COUNT));
      end
    end
  end

  assign slot_free = !out_valid_r || out_chan.ready;

  // sequencer: next state, memory controls and result
  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    prev_nxt   = prev_r;
    cur_nxt    = cur_r;
    mem_re     = 1'b0;
    mem_ra     = '0;
    mem_we     = 1'b0;
    mem_wa     = '0;
    mem_wd     = '0;
    out_load   = 1'b0;
    res_value  = 1'b0;
    res_status = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_chan.valid) begin
          cnt_nxt  = '0;
          prev_nxt = '0;
          cur_nxt  = '0;
          if (in_oob) begin
            state_nxt = ST_RESP;
          end else begin
            unique case (lgge_op_t'(in_chan.operation))
              OP_READ:   state_nxt = ST_READ_ROW;
              OP_TOGGLE: state_nxt = ST_READ_ROW;
              OP_FILL:   state_nxt = ST_FILL;
              OP_STEP:   state_nxt = ST_STEP;
              default:   state_nxt = ST_IDLE;
            endcase
          end
        end
      end
      // read-modify-write of every active row
      ST_FILL: begin
        cnt_nxt = cnt_r + CW'(1);
        if (SIDE_W'(cnt_r) < eff_side) begin
          mem_re = 1'b1;
          mem_ra = cnt_r[AW-1:0];
        end
        if (cnt_r != '0) begin
          mem_we = 1'b1;
          mem_wa = cnt_m1[AW-1:0];
          mem_wd = fill_r ? (rdata | side_mask) : (rdata & ~side_mask);
        end
        if (SIDE_W'(cnt_r) == eff_side) begin
          state_nxt = ST_READ_ROW;
        end
      end
      // three-row window of the old generation slides down the grid
      ST_STEP: begin
        cnt_nxt = cnt_r + CW'(1);
        if (SIDE_W'(cnt_r) < eff_side) begin
          mem_re = 1'b1;
          mem_ra = cnt_r[AW-1:0];
        end
        if (cnt_r != '0) begin
          prev_nxt = cur_r;
          cur_nxt  = next_in;
        end
        if (cnt_r >= CW'(2)) begin
          mem_we = 1'b1;
          mem_wa = cnt_m2[AW-1:0];
          mem_wd = new_row;
        end
        if (SIDE_W'(cnt_r) == eff_side + SIDE_W'(1)) begin
          state_nxt = ST_READ_ROW;
        end
      end
      ST_READ_ROW: begin
        mem_re    = 1'b1;
        mem_ra    = x_r[AW-1:0];
        state_nxt = ST_RESP;
      end
      // result waits here until the output register frees
      ST_RESP: begin
        if (slot_free) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
          if (oob_r) begin
            res_status = 1'b1;
          end else if (op_r == OP_TOGGLE) begin
            mem_we    = 1'b1;
            mem_wa    = x_r[AW-1:0];
            mem_wd    = rdata ^ y_bit;
            res_value = !rdata[y_r[AW-1:0]];
          end else begin
            res_value = rdata[y_r[AW-1:0]];
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // command capture and step window
  always_ff @(posedge clk) begin
    prev_r <= prev_nxt;
    cur_r  <= cur_nxt;
    if (in_xfer) begin
      op_r   <= lgge_op_t'(in_chan.operation);
      x_r    <= in_chan.cell_x;
      y_r    <= in_chan.cell_y;
      fill_r <= in_chan.fill_value;
      oob_r  <= in_oob;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_value_r  <= res_value;
      out_status_r <= res_status;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.cell_value = out_value_r;
  assign out_chan.status     = out_status_r;

endmodule : life_grid_generation_engine

/* rtl/core/lgge_checker.sv */
// ----------------------------------------------------------------------------
// lgge_checker
// Port-level checks of the life grid generation engine, bound to the top.
// ----------------------------------------------------------------------------
module lgge_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_cell_value,
  input logic out_status
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // an outside-grid result never reports a live cell
  a_oob_dead: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> !out_cell_value)
    else $error("outside-grid result shows a live cell");

  // one command at a time: busy right after a command transfer
  a_busy_after_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("command taken while previous one in work");

  // a new result comes only out of work in progress
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared while idle");

endmodule : lgge_checker

bind life_grid_generation_engine lgge_checker u_lgge_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_chan.valid),
  .in_ready       (in_chan.ready),
  .out_valid      (out_chan.valid),
  .out_ready      (out_chan.ready),
  .out_cell_value (out_chan.cell_value),
  .out_status     (out_chan.status)
);
